/* sv/nwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nwt_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam logic OP_SET     = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NEG  = 2'd2;

    localparam logic signed [31:0] MIN_INIT   = 32'sd10000;
    localparam logic signed [31:0] MIN_ALARM  = 32'sd2;
    localparam logic signed [31:0] STALE_DIFF = -32'sd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

/* sv/named_wake_timer_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Named wake timer table. An item is taken when start is high and busy is low; its
// result appears on alarm_time/status for exactly one cycle with done high, once the
// scan, drain and finish states are through, and a new item may be started in that
// same cycle. Each item walks the whole table one entry per cycle through the key/expiry
// memory read port, so the block takes no new item until the last one is done. There is
// no back-pressure: the receiver must take the result in the cycle done is high.
module named_wake_timer_table_unit #(
    parameter int ENTRIES = nwt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               opcode,
    input  wire logic [63:0]        name_key,
    input  wire logic signed [31:0] delay_seconds,
    input  wire logic [31:0]        current_time,
    output logic                    done,
    output logic [31:0]             alarm_time,
    output logic [1:0]              status
);
    import nwt_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    nwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    nwt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .opcode        (opcode),
        .name_key      (name_key),
        .delay_seconds (delay_seconds),
        .current_time  (current_time),
        .done          (done),
        .alarm_time    (alarm_time),
        .status        (status)
    );

endmodule
`default_nettype wire

/* sv/nwt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module nwt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire nwt_pkg::dp_status_t dp_status,
    output nwt_pkg::dp_cmd_t        dp_cmd
);
    import nwt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                dp_cmd.issue = 1'b1;
                if (dp_status.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                dp_cmd.finish = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/nwt_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module nwt_dp #(
    parameter int ENTRIES = nwt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nwt_pkg::dp_cmd_t    dp_cmd,
    output nwt_pkg::dp_status_t      dp_status,
    input  wire logic                opcode,
    input  wire logic [63:0]         name_key,
    input  wire logic signed [31:0]  delay_seconds,
    input  wire logic [31:0]         current_time,
    output logic                     done,
    output logic [31:0]              alarm_time,
    output logic [1:0]               status
);
    import nwt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [63:0]        key_mem [ENTRIES];
    logic [31:0]        exp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic               opcode_reg;
    logic [63:0]        key_reg;
    logic signed [31:0] delay_reg;
    logic [31:0]        now_reg;

    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   proc_idx_reg;
    logic               proc_vld_reg;
    logic [63:0]        key_rd_reg;
    logic [31:0]        exp_rd_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic signed [31:0] min_reg;

    logic               done_reg;
    logic [31:0]        alarm_reg;
    logic [1:0]         status_reg;

    logic               ent_valid;
    logic signed [31:0] diff;
    logic               stale;
    logic               set_pos;
    logic               set_zero;
    logic               set_neg;
    logic               key_we;
    logic               exp_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [31:0]        alarm_next;
    logic [1:0]         status_next;

    assign dp_status.last = (cnt_reg == IDX_W'(ENTRIES - 1));

    assign ent_valid = valid_reg[proc_idx_reg];
    assign diff      = signed'(exp_rd_reg - now_reg);
    assign stale     = (diff <= STALE_DIFF);

    assign set_neg  = delay_reg[31];
    assign set_zero = (delay_reg == 32'sd0);
    assign set_pos  = !set_neg && !set_zero;

    always_comb
    begin
        key_we      = 1'b0;
        exp_we      = 1'b0;
        wr_idx      = found_idx_reg;
        alarm_next  = 32'd0;
        status_next = STATUS_OK;
        if (opcode_reg == OP_COMPUTE)
        begin
            if (min_reg < MIN_ALARM)
            begin
                alarm_next = now_reg + unsigned'(MIN_ALARM);
            end
            else
            begin
                alarm_next = now_reg + unsigned'(min_reg);
            end
        end
        else if (set_neg)
        begin
            status_next = STATUS_NEG;
        end
        else if (set_pos)
        begin
            if (found_reg)
            begin
                exp_we = dp_cmd.finish;
            end
            else if (free_found_reg)
            begin
                wr_idx = free_idx_reg;
                key_we = dp_cmd.finish;
                exp_we = dp_cmd.finish;
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (exp_we)
        begin
            exp_mem[wr_idx] <= now_reg + unsigned'(delay_reg);
        end
        if (dp_cmd.issue)
        begin
            key_rd_reg <= key_mem[cnt_reg];
            exp_rd_reg <= exp_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            opcode_reg <= opcode;
            key_reg    <= name_key;
            delay_reg  <= delay_seconds;
            now_reg    <= current_time;
            min_reg    <= MIN_INIT;
        end
        else if (proc_vld_reg && ent_valid && !stale && diff < min_reg)
        begin
            min_reg <= diff;
        end
        if (dp_cmd.issue)
        begin
            proc_idx_reg <= cnt_reg;
        end
        if (proc_vld_reg && ent_valid && key_rd_reg == key_reg)
        begin
            found_idx_reg <= proc_idx_reg;
        end
        if (proc_vld_reg && !ent_valid && !free_found_reg)
        begin
            free_idx_reg <= proc_idx_reg;
        end
        if (dp_cmd.finish)
        begin
            alarm_reg  <= alarm_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cnt_reg        <= '0;
            proc_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg     <= dp_cmd.finish;
            proc_vld_reg <= dp_cmd.issue;
            if (dp_cmd.load)
            begin
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (dp_cmd.issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (proc_vld_reg)
            begin
                if (ent_valid && key_rd_reg == key_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!ent_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (opcode_reg == OP_COMPUTE && ent_valid && stale)
                begin
                    valid_reg[proc_idx_reg] <= 1'b0;
                end
            end
            if (dp_cmd.finish && opcode_reg == OP_SET)
            begin
                if (set_zero && found_reg)
                begin
                    valid_reg[found_idx_reg] <= 1'b0;
                end
                else if (key_we)
                begin
                    valid_reg[wr_idx] <= 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign alarm_time = alarm_reg;
    assign status     = status_reg;

endmodule
`default_nettype wire
